// ----- hdl/adsr_pkg.sv -----
`timescale 1ns / 1ps

package adsr_pkg;

   localparam int TIME_FRAC_BITS = 24;
   localparam int TIME_W         = TIME_FRAC_BITS + 1;
   localparam int LEVEL_FRAC     = 15;
   localparam int LEVEL_W        = 16;
   localparam int LEVEL_SHIFT    = TIME_FRAC_BITS - LEVEL_FRAC;
   localparam int SAMPLE_W       = 16;
   localparam int STEP_W         = 16;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [STEP_W-1:0]  step_type;

   localparam time_type T_ONE = time_type'(64'd1 << TIME_FRAC_BITS);
   localparam time_type T_0P3 = time_type'(((64'd3 << TIME_FRAC_BITS) + 64'd5) / 64'd10);
   localparam time_type T_0P7 = time_type'(((64'd7 << TIME_FRAC_BITS) + 64'd5) / 64'd10);

   localparam level_type LEVEL_ONE = level_type'(T_ONE >> LEVEL_SHIFT);
   localparam level_type LEVEL_0P7 = level_type'(T_0P7 >> LEVEL_SHIFT);

   localparam step_type STEP_RESET = step_type'(350);

   localparam logic [CSR_IDX_W-1:0] REG_ATTACK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUSTAIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef struct packed {
      step_type attack_step;
      step_type decay_step;
      step_type sustain_step;
      step_type release_step;
   } steps_type;

endpackage

// ----- hdl/adsr_env.sv -----
`timescale 1ns / 1ps

module adsr_env
   import adsr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic      gate,
   input  steps_type steps,
   output level_type level,
   output phase_type phase_now
);

   phase_type phase_ff;
   phase_type phase_in;
   time_type  elapsed_ff;
   time_type  elapsed_in;
   time_type  base;
   time_type  t_val;
   step_type  spd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      phase_now = phase_ff;
      base      = elapsed_ff;
      spd       = '0;
      t_val     = '0;
      unique case (phase_ff)
         PH_ATTACK: begin
            spd = steps.attack_step;
            if (elapsed_ff >= T_ONE) begin
               base     = elapsed_ff - T_ONE;
               t_val    = T_ONE;
               phase_in = PH_DECAY;
            end else begin
               t_val = elapsed_ff;
            end
         end
         PH_DECAY: begin
            spd = steps.decay_step;
            if (elapsed_ff >= T_0P3) begin
               base     = elapsed_ff - T_0P3;
               t_val    = T_0P7;
               phase_in = PH_SUSTAIN;
            end else begin
               t_val = T_ONE - elapsed_ff;
            end
         end
         PH_SUSTAIN: begin
            spd   = steps.sustain_step;
            t_val = T_0P7;
            base  = '0;
            if (!gate) begin
               phase_in = PH_RELEASE;
            end
         end
         PH_RELEASE: begin
            spd = steps.release_step;
            if (elapsed_ff >= T_0P7) begin
               t_val    = '0;
               phase_in = PH_IDLE;
            end else begin
               t_val = T_0P7 - elapsed_ff;
            end
         end
         default: begin
            phase_now = PH_IDLE;
            base      = '0;
            phase_in  = gate ? PH_ATTACK : PH_IDLE;
         end
      endcase
      elapsed_in = base + time_type'(spd);
   end

   assign level = t_val[TIME_W-1:LEVEL_SHIFT];

endmodule

// ----- hdl/adsr_vca.sv -----
`timescale 1ns / 1ps

module adsr_vca
   import adsr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [SAMPLE_W-1:0] in_sample,
   input  level_type                  in_level,
   input  phase_type                  in_phase,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output level_type                  rsp_level,
   output logic [2:0]                 rsp_phase_now
);

   logic                              valid_ff;
   logic signed [SAMPLE_W-1:0]        sample_ff;
   level_type                         level_ff;
   phase_type                         phase_ff;
   logic signed [SAMPLE_W+LEVEL_W:0]  prod;

   assign free = !valid_ff || !rsp_stall;
   assign prod = $signed({1'b0, in_level}) * in_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (free && in_valid) begin
         sample_ff <= prod[LEVEL_FRAC+SAMPLE_W-1:LEVEL_FRAC];
         level_ff  <= in_level;
         phase_ff  <= in_phase;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_sample_out = sample_ff;
   assign rsp_level      = level_ff;
   assign rsp_phase_now  = phase_ff;

endmodule

// ----- hdl/adsr_envelope_vca.sv -----
// A beat accepted on the req side passes through the s1 registers, then the VCA output registers, to rsp.
// Throughput: one beat per cycle unless rsp_stall holds the pipeline; the envelope state update
// (compare, subtract, add) closes in the cycle a beat is accepted; the gain multiply reads s1.
// Reset (synchronous, active high): phase idle, elapsed time zero, all steps 350,
// both pipeline stages empty.
`timescale 1ns / 1ps

module adsr_envelope_vca
   import adsr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   input  logic                         req_gate,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   output logic [LEVEL_W-1:0]           rsp_level,
   output logic [2:0]                   rsp_phase_now,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   steps_type                  steps_ff;
   logic                       s1_valid_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   level_type                  s1_level_ff;
   phase_type                  s1_phase_ff;
   logic                       req_accept;
   logic                       vca_free;
   level_type                  env_level;
   phase_type                  env_phase;

   assign csr_ready  = 1'b1;
   assign req_stall  = s1_valid_ff && !vca_free;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff.attack_step  <= STEP_RESET;
         steps_ff.decay_step   <= STEP_RESET;
         steps_ff.sustain_step <= STEP_RESET;
         steps_ff.release_step <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ATTACK:  steps_ff.attack_step  <= step_type'(csr_data);
            REG_DECAY:   steps_ff.decay_step   <= step_type'(csr_data);
            REG_SUSTAIN: steps_ff.sustain_step <= step_type'(csr_data);
            REG_RELEASE: steps_ff.release_step <= step_type'(csr_data);
         endcase
      end
   end

   adsr_env u_env (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .gate      (req_gate),
      .steps     (steps_ff),
      .level     (env_level),
      .phase_now (env_phase)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || vca_free) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_sample_in;
         s1_level_ff  <= env_level;
         s1_phase_ff  <= env_phase;
      end
   end

   adsr_vca u_vca (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s1_valid_ff),
      .in_sample      (s1_sample_ff),
      .in_level       (s1_level_ff),
      .in_phase       (s1_phase_ff),
      .free           (vca_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_level      (rsp_level),
      .rsp_phase_now  (rsp_phase_now)
   );

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level <= LEVEL_ONE)
      else $error("level above full scale");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase_now == PH_IDLE) |-> (rsp_level == '0 && rsp_sample_out == '0))
      else $error("idle beat with nonzero level or sample");

   a_sustain_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase_now == PH_SUSTAIN) |-> rsp_level == LEVEL_0P7)
      else $error("sustain beat off the sustain level");

   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && s1_valid_ff) |-> req_stall)
      else $error("input taken while both stages are full and blocked");

endmodule
